// File: rtl/dass_pkg.sv
// ----------------------------------------------------------------------------
// dass_pkg
// shared types, constants and the coil table of the dual axis stepper sequencer
// ----------------------------------------------------------------------------
package dass_pkg;

  // action codes of an input beat
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_MOVE = 2'd1;
  localparam logic [1:0] ACT_HOME = 2'd2;

  // move status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // configuration register indexes
  localparam logic CFG_PAN_LIMIT  = 1'b0;
  localparam logic CFG_TILT_LIMIT = 1'b1;

  localparam logic [15:0] LIMIT_RESET       = 16'd1024;
  localparam logic [15:0] ENDLESS_THRESHOLD = 16'd1024;
  localparam logic [15:0] DEG_DIVISOR       = 16'd45;
  localparam logic [3:0]  COILS_OFF         = 4'h0;

  // q7 fixed point: ratio and accumulator are a 16 bit count shifted by 7
  localparam int unsigned Q_SHIFT   = 7;
  localparam int unsigned RATIO_W   = 16 + Q_SHIFT;
  localparam int unsigned DIV_STEPS = RATIO_W;
  localparam logic [RATIO_W:0] Q_ONE = (RATIO_W + 1)'(1 << Q_SHIFT);

  typedef struct packed {
    logic [1:0]  action;
    logic        pan_enable;
    logic        tilt_enable;
    logic [15:0] pan_amount;
    logic [15:0] tilt_amount;
    logic        pan_in_degrees;
    logic        tilt_in_degrees;
    logic        pan_reverse;
    logic        tilt_reverse;
    logic        pan_origin_switch;
    logic        tilt_end_switch;
  } in_item_t;

  typedef struct packed {
    logic [3:0] pan_coils;
    logic [3:0] tilt_coils;
    logic       busy_res;
    logic [1:0] move_status;
    logic       pan_active;
    logic       tilt_active;
  } out_item_t;

  // request to and response from the shared divider
  typedef struct packed {
    logic               start;
    logic [RATIO_W-1:0] dividend;
    logic [15:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [RATIO_W-1:0] quotient;
  } div_rsp_t;

  // per axis state: flags, rhythm, period count, position and coil drive
  typedef struct packed {
    logic        run;
    logic        pd;
    logic        rev;
    logic        red;
    logic        ini;
    logic [2:0]  rhythm;
    logic [15:0] periods;
    logic [15:0] position;
    logic [3:0]  coils;
  } axis_state_t;

  // pending move command
  typedef struct packed {
    logic        pen;
    logic        ten;
    logic        pdeg;
    logic        tdeg;
    logic        prev;
    logic        trev;
    logic [15:0] pamt;
    logic [15:0] tamt;
  } move_t;

  // half step coil table
  function automatic logic [3:0] coil_pattern(input logic [2:0] ph);
    logic [3:0] c;
    case (ph)
      3'd0:    c = 4'h1;
      3'd1:    c = 4'h3;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h6;
      3'd4:    c = 4'h4;
      3'd5:    c = 4'hC;
      3'd6:    c = 4'h8;
      3'd7:    c = 4'h9;
      default: c = COILS_OFF;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/dass_div.sv
// ----------------------------------------------------------------------------
// dass_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dass_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dass_pkg::div_req_t req_i,
  output dass_pkg::div_rsp_t rsp_o
);
  import dass_pkg::*;

  localparam int unsigned CntW = $clog2(DIV_STEPS + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [RATIO_W-1:0] quo_q, quo_d;
  logic [15:0]        rem_q, rem_d;
  logic [15:0]        dsr_q, dsr_d;
  logic [16:0]        shifted;
  logic [16:0]        diff;
  logic               take;

  assign shifted = {rem_q, quo_q[RATIO_W-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign take    = (shifted >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DIV_STEPS);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = take ? diff[15:0] : shifted[15:0];
      quo_d = {quo_q[RATIO_W-2:0], take};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: rtl/dual_axis_stepper_sequencer.sv
// ----------------------------------------------------------------------------
// dual_axis_stepper_sequencer
// half step sequencer for a pan and a tilt stepper with moves and homing
// ----------------------------------------------------------------------------
// Each input beat is one action: a timer tick, a move command or a homing
// scan start, and it returns exactly one result beat with both coil drives,
// the homing busy bit, the move status and the running flags. The block takes
// one beat at a time and stalls its input until that beat's work is done; a
// finished result waits in an output register, so the next beat is taken while
// it is still unread. A tick passes through S_TICK and then S_DONE, a homing
// start or an ignored action goes straight to S_DONE, and the input is free
// again once S_DONE loads the result. A move runs a sequencer around one shared
// restoring divider; each division runs through its quotient steps and then
// flags done. A degree amount costs one division per enabled axis and a
// two-axis move one more for the q7 speed ratio. A homing tick that ends the
// scan starts the return move, with its ratio division if both axes go back.
// A result that is still stalled holds the block until the output register
// frees. Travel limits are written through the plain configuration port; the
// user must write them only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
module dual_axis_stepper_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dass_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dass_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import dass_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_TICK       = 4'd1;
  localparam logic [3:0] S_MV_START   = 4'd2;
  localparam logic [3:0] S_WAIT_P     = 4'd3;
  localparam logic [3:0] S_CHK_P      = 4'd4;
  localparam logic [3:0] S_TILT_START = 4'd5;
  localparam logic [3:0] S_WAIT_T     = 4'd6;
  localparam logic [3:0] S_CHK_T      = 4'd7;
  localparam logic [3:0] S_WAIT_R     = 4'd8;
  localparam logic [3:0] S_DONE       = 4'd9;

  logic [3:0]         state_q, state_d;
  in_item_t           in_q, in_d;
  axis_state_t        pan_q, pan_d;
  axis_state_t        tilt_q, tilt_d;
  logic               homing_q, homing_d;
  logic [RATIO_W-1:0] ratio_q, ratio_d;
  logic [RATIO_W-1:0] acc_q, acc_d;
  logic [15:0]        pan_limit_q, pan_limit_d;
  logic [15:0]        tilt_limit_q, tilt_limit_d;
  move_t              mv_q, mv_d;
  logic [15:0]        ps_q, ps_d;
  logic [15:0]        ts_q, ts_d;
  logic [1:0]         status_q, status_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // normal tick results
  logic [RATIO_W:0]   d_sum;
  logic               d_hit;
  logic [RATIO_W-1:0] d_acc;
  axis_state_t        d_pan, d_tilt;

  // homing tick results
  axis_state_t        h_pan, h_tilt;
  logic               h_ret;

  dass_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // one drive tick of an axis; gate comes from the ratio accumulator
  function automatic axis_state_t drive_axis(input axis_state_t a, input logic gate);
    axis_state_t n;
    logic        stop;
    logic [2:0]  ph;
    n    = a;
    stop = 1'b0;
    ph   = a.rev ? ~a.rhythm : a.rhythm;
    if (a.run && gate) begin
      if (a.pd) begin
        if (a.periods != 16'd0 && a.periods <= ENDLESS_THRESHOLD) begin
          n.periods = a.periods - 16'd1;
        end else if (a.periods == 16'd0) begin
          // count used up: coils off, axis done
          n.run   = 1'b0;
          n.pd    = 1'b0;
          n.ini   = 1'b0;
          n.coils = COILS_OFF;
          stop    = 1'b1;
        end
        if (!stop) n.pd = 1'b0;
      end
      if (!stop) begin
        n.coils  = coil_pattern(ph);
        n.rhythm = a.rhythm + 3'd1;
        // rhythm wrap closes a period
        if (a.rhythm == 3'd7) n.pd = 1'b1;
      end
    end
    return n;
  endfunction

  // ratio accumulator: only one axis can carry the reducing mark
  assign d_sum = {1'b0, acc_q} + Q_ONE;
  assign d_hit = (d_sum >= {1'b0, ratio_q});

  always_comb begin
    d_acc = acc_q;
    if ((pan_q.run && pan_q.red) || (tilt_q.run && tilt_q.red)) begin
      d_acc = d_hit ? RATIO_W'(d_sum - {1'b0, ratio_q}) : d_sum[RATIO_W-1:0];
    end
    d_pan  = drive_axis(pan_q, !pan_q.red || d_hit);
    d_tilt = drive_axis(tilt_q, !tilt_q.red || d_hit);
  end

  // homing tick: pan forward to its origin, tilt in reverse to its end switch
  always_comb begin
    h_pan  = pan_q;
    h_tilt = tilt_q;
    h_ret  = 1'b0;
    if (pan_q.run) begin
      if (pan_q.pd) begin
        h_pan.position = pan_q.position + 16'd1;
        h_pan.pd       = 1'b0;
        if (!in_q.pan_origin_switch) begin
          h_pan.run = 1'b0;
          if (!tilt_q.run) h_ret = 1'b1;
        end
      end
      if (!h_ret) begin
        h_pan.coils  = coil_pattern(pan_q.rhythm);
        h_pan.rhythm = pan_q.rhythm + 3'd1;
        if (pan_q.rhythm == 3'd7) h_pan.pd = 1'b1;
      end
    end
    if (!h_ret && tilt_q.run) begin
      if (tilt_q.pd) begin
        h_tilt.position = tilt_q.position + 16'd1;
        h_tilt.pd       = 1'b0;
        if (!in_q.tilt_end_switch) begin
          h_tilt.run = 1'b0;
          if (!h_pan.run) h_ret = 1'b1;
        end
      end
      if (!h_ret) begin
        h_tilt.coils  = coil_pattern(~tilt_q.rhythm);
        h_tilt.rhythm = tilt_q.rhythm + 3'd1;
        if (tilt_q.rhythm == 3'd7) h_tilt.pd = 1'b1;
      end
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // main sequencer
  always_comb begin
    state_d      = state_q;
    in_d         = in_q;
    pan_d        = pan_q;
    tilt_d       = tilt_q;
    homing_d     = homing_q;
    ratio_d      = ratio_q;
    acc_d        = acc_q;
    pan_limit_d  = pan_limit_q;
    tilt_limit_d = tilt_limit_q;
    mv_d         = mv_q;
    ps_d         = ps_q;
    ts_d         = ts_q;
    status_d     = status_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    div_req      = '0;

    // result beat taken
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PAN_LIMIT:  pan_limit_d  = cfg_data_i;
        CFG_TILT_LIMIT: tilt_limit_d = cfg_data_i;
        default:        pan_limit_d  = pan_limit_q;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d     = in_data_i;
          status_d = ST_OK;
          unique case (in_data_i.action)
            ACT_TICK: state_d = S_TICK;
            ACT_MOVE: begin
              mv_d.pen  = in_data_i.pan_enable;
              mv_d.ten  = in_data_i.tilt_enable;
              mv_d.pdeg = in_data_i.pan_in_degrees;
              mv_d.tdeg = in_data_i.tilt_in_degrees;
              mv_d.prev = in_data_i.pan_reverse;
              mv_d.trev = in_data_i.tilt_reverse;
              mv_d.pamt = in_data_i.pan_amount;
              mv_d.tamt = in_data_i.tilt_amount;
              state_d   = S_MV_START;
            end
            ACT_HOME: begin
              // all flags cleared, then both axes run and initing
              pan_d.rev      = 1'b0;
              pan_d.red      = 1'b0;
              pan_d.run      = 1'b1;
              pan_d.pd       = 1'b1;
              pan_d.ini      = 1'b1;
              pan_d.position = '0;
              tilt_d.rev      = 1'b0;
              tilt_d.red      = 1'b0;
              tilt_d.run      = 1'b1;
              tilt_d.pd       = 1'b1;
              tilt_d.ini      = 1'b1;
              tilt_d.position = '0;
              homing_d        = 1'b1;
              state_d         = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_TICK: begin
        if (homing_q) begin
          pan_d  = h_pan;
          tilt_d = h_tilt;
          if (h_ret) begin
            // scan over: clear positions and move back by one period less
            homing_d        = 1'b0;
            pan_d.position  = '0;
            tilt_d.position = '0;
            mv_d.pen        = (h_pan.position != 16'd0);
            mv_d.ten        = (h_tilt.position != 16'd0);
            mv_d.pdeg       = 1'b0;
            mv_d.tdeg       = 1'b0;
            mv_d.prev       = 1'b1;
            mv_d.trev       = 1'b0;
            mv_d.pamt       = h_pan.position - 16'd1;
            mv_d.tamt       = h_tilt.position - 16'd1;
            state_d         = S_MV_START;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          pan_d   = d_pan;
          tilt_d  = d_tilt;
          acc_d   = d_acc;
          state_d = S_DONE;
        end
      end

      S_MV_START: begin
        pan_d.red  = 1'b0;
        tilt_d.red = 1'b0;
        if (mv_q.pen) begin
          if (mv_q.pdeg) begin
            div_req.start    = 1'b1;
            div_req.dividend = {{Q_SHIFT{1'b0}}, mv_q.pamt[15-Q_SHIFT:0], {Q_SHIFT{1'b0}}};
            div_req.divisor  = DEG_DIVISOR;
            state_d          = S_WAIT_P;
          end else begin
            ps_d    = mv_q.pamt;
            state_d = S_CHK_P;
          end
        end else begin
          state_d = S_TILT_START;
        end
      end

      S_WAIT_P: begin
        if (div_rsp.done) begin
          ps_d    = div_rsp.quotient[15:0];
          state_d = S_CHK_P;
        end
      end

      S_CHK_P: begin
        if (ps_q == 16'd0) begin
          status_d = ST_ZERO;
          state_d  = S_DONE;
        end else if (({1'b0, ps_q} + {1'b0, pan_q.position}) > {1'b0, pan_limit_q}) begin
          status_d = ST_RANGE;
          state_d  = S_DONE;
        end else begin
          pan_d.rev     = mv_q.prev;
          pan_d.periods = ps_q;
          pan_d.run     = 1'b1;
          pan_d.pd      = 1'b1;
          state_d       = S_TILT_START;
        end
      end

      S_TILT_START: begin
        if (mv_q.ten) begin
          if (mv_q.tdeg) begin
            div_req.start    = 1'b1;
            div_req.dividend = {{Q_SHIFT{1'b0}}, mv_q.tamt[15-Q_SHIFT:0], {Q_SHIFT{1'b0}}};
            div_req.divisor  = DEG_DIVISOR;
            state_d          = S_WAIT_T;
          end else begin
            ts_d    = mv_q.tamt;
            state_d = S_CHK_T;
          end
        end else begin
          state_d = S_DONE;
        end
      end

      S_WAIT_T: begin
        if (div_rsp.done) begin
          ts_d    = div_rsp.quotient[15:0];
          state_d = S_CHK_T;
        end
      end

      S_CHK_T: begin
        if (ts_q == 16'd0) begin
          status_d = ST_ZERO;
          state_d  = S_DONE;
        end else if (({1'b0, ts_q} + {1'b0, tilt_q.position}) > {1'b0, tilt_limit_q}) begin
          status_d = ST_RANGE;
          state_d  = S_DONE;
        end else begin
          tilt_d.rev     = mv_q.trev;
          tilt_d.periods = ts_q;
          tilt_d.run     = 1'b1;
          tilt_d.pd      = 1'b1;
          if (mv_q.pen) begin
            // two-axis move: the shorter axis gets the reducing mark, pan on a tie
            acc_d         = '0;
            div_req.start = 1'b1;
            if (ps_q > ts_q) begin
              div_req.dividend = {ps_q, {Q_SHIFT{1'b0}}};
              div_req.divisor  = ts_q;
              tilt_d.red       = 1'b1;
            end else begin
              div_req.dividend = {ts_q, {Q_SHIFT{1'b0}}};
              div_req.divisor  = ps_q;
              pan_d.red        = 1'b1;
            end
            state_d = S_WAIT_R;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_WAIT_R: begin
        if (div_rsp.done) begin
          ratio_d = div_rsp.quotient;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        // load the result beat once the register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.pan_coils   = pan_q.coils;
          out_d.tilt_coils  = tilt_q.coils;
          out_d.busy_res    = pan_q.ini | tilt_q.ini;
          out_d.move_status = (in_q.action == ACT_MOVE) ? status_q : ST_OK;
          out_d.pan_active  = pan_q.run;
          out_d.tilt_active = tilt_q.run;
          state_d           = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pan_q        <= '0;
      tilt_q       <= '0;
      homing_q     <= 1'b0;
      ratio_q      <= '0;
      acc_q        <= '0;
      pan_limit_q  <= LIMIT_RESET;
      tilt_limit_q <= LIMIT_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pan_q        <= pan_d;
      tilt_q       <= tilt_d;
      homing_q     <= homing_d;
      ratio_q      <= ratio_d;
      acc_q        <= acc_d;
      pan_limit_q  <= pan_limit_d;
      tilt_limit_q <= tilt_limit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_q     <= in_d;
    mv_q     <= mv_d;
    ps_q     <= ps_d;
    ts_q     <= ts_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/dass_checker.sv
// ----------------------------------------------------------------------------
// dass_checker
// port level assertions for the dual axis stepper sequencer
// ----------------------------------------------------------------------------
module dass_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dass_pkg::out_item_t out_data_o
);
  import dass_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // one beat at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the beat was worked");

  // a result never shows up in the cycle right after its accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result beat appeared too early");

  // move status only carries its defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.move_status == ST_OK || out_data_o.move_status == ST_ZERO ||
                     out_data_o.move_status == ST_RANGE))
    else $error("undefined move status");

endmodule

bind dual_axis_stepper_sequencer dass_checker u_dass_checker (.*);

// File: tb/dual_axis_stepper_sequencer_test.sv
// ----------------------------------------------------------------------------
// dual_axis_stepper_sequencer_test
// self checking testbench for the pan and tilt half step sequencer
// ----------------------------------------------------------------------------
// Beats go in through the valid/stall input channel. A behavioral predictor
// of the sequencer runs on every accepted beat, and its expected result beats
// are compared field by field with the result beats that come out. Directed
// tests cover move status codes, degree conversion, ratio slowing, homing and
// the travel limit extremes. Random traffic then runs under several handshake
// mixes and limit settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_axis_stepper_sequencer_test;
  import dass_pkg::*;

  // action code the block ignores, not in the package
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam int          CYCLE_LIMIT = 400000;
  // half step coil table, entry n at bits 4n+3..4n
  localparam logic [31:0] HALF_STEP_COILS = 32'h98C4_6231;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_beat = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_beat;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  // handshake pressure, percent of cycles
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  int          cycles = 0;
  int          mismatches = 0;
  int          results_checked = 0;
  int          ticks_sent = 0;
  int          moves_sent = 0;
  int          moves_refused = 0;
  int          scans_sent = 0;

  // predicted result beats, oldest first
  out_item_t   pending_results[$];

  // predictor state
  logic [15:0] pan_limit_m = LIMIT_RESET;
  logic [15:0] tilt_limit_m = LIMIT_RESET;
  axis_state_t pan_m = '0;
  axis_state_t tilt_m = '0;
  logic        homing_m = 1'b0;
  logic [31:0] ratio_m = '0;
  logic [31:0] accum_m = '0;

  dual_axis_stepper_sequencer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  function automatic logic [15:0] periods_of(input logic [15:0] amt, input logic deg);
    logic [15:0] shifted;
    // degrees: amount times 128, kept to 16 bits, over 45
    shifted = {amt[8:0], 7'd0};
    return deg ? shifted / DEG_DIVISOR : amt;
  endfunction

  function automatic axis_state_t next_rhythm(input axis_state_t ax);
    ax.rhythm = ax.rhythm + 3'd1;
    // wrap from 7 to 0 closes a period
    if (ax.rhythm == 3'd0) ax.pd = 1'b1;
    return ax;
  endfunction

  // q7 accumulator lets the slowed axis step only on some ticks
  function automatic logic step_granted(input logic red);
    if (!red) return 1'b1;
    accum_m = accum_m + (32'd1 << Q_SHIFT);
    if (accum_m >= ratio_m) begin
      accum_m = accum_m - ratio_m;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic axis_state_t drive_axis(input axis_state_t ax);
    logic [2:0] ph;
    if (!ax.run) return ax;
    if (!step_granted(ax.red)) return ax;
    if (ax.pd) begin
      if (ax.periods == 16'd0) begin
        // count used up: coils off
        ax.run   = 1'b0;
        ax.pd    = 1'b0;
        ax.ini   = 1'b0;
        ax.coils = COILS_OFF;
        return ax;
      end
      // above the threshold the count is never used up
      if (ax.periods <= ENDLESS_THRESHOLD) ax.periods = ax.periods - 16'd1;
      ax.pd = 1'b0;
    end
    ph = ax.rev ? 3'd7 - ax.rhythm : ax.rhythm;
    ax.coils = HALF_STEP_COILS[{ph, 2'b00} +: 4];
    return next_rhythm(ax);
  endfunction

  function automatic logic [1:0] load_move(input in_item_t m);
    logic [15:0] ps;
    logic [15:0] ts;
    ps = periods_of(m.pan_amount, m.pan_in_degrees);
    ts = periods_of(m.tilt_amount, m.tilt_in_degrees);
    pan_m.red  = 1'b0;
    tilt_m.red = 1'b0;
    if (m.pan_enable) begin
      // a refused pan part ends the command
      if (ps == 16'd0) return ST_ZERO;
      if (({1'b0, ps} + {1'b0, pan_m.position}) > {1'b0, pan_limit_m}) return ST_RANGE;
      pan_m.rev     = m.pan_reverse;
      pan_m.periods = ps;
      pan_m.run     = 1'b1;
      pan_m.pd      = 1'b1;
    end
    if (m.tilt_enable) begin
      if (ts == 16'd0) return ST_ZERO;
      if (({1'b0, ts} + {1'b0, tilt_m.position}) > {1'b0, tilt_limit_m}) return ST_RANGE;
      tilt_m.rev     = m.tilt_reverse;
      tilt_m.periods = ts;
      tilt_m.run     = 1'b1;
      tilt_m.pd      = 1'b1;
      if (m.pan_enable) begin
        // the axis with fewer periods is slowed, pan on a tie
        accum_m = '0;
        if (ps > ts) begin
          ratio_m    = {9'd0, ps, 7'd0} / {16'd0, ts};
          tilt_m.red = 1'b1;
        end else begin
          ratio_m   = {9'd0, ts, 7'd0} / {16'd0, ps};
          pan_m.red = 1'b1;
        end
      end
    end
    return ST_OK;
  endfunction

  // both switches found: move back, pan in reverse and tilt forward
  function automatic void start_return();
    in_item_t m;
    m = '0;
    m.pan_enable   = pan_m.position != 16'd0;
    m.tilt_enable  = tilt_m.position != 16'd0;
    m.pan_amount   = pan_m.position - 16'd1;
    m.tilt_amount  = tilt_m.position - 16'd1;
    m.pan_reverse  = 1'b1;
    homing_m       = 1'b0;
    pan_m.position  = '0;
    tilt_m.position = '0;
    void'(load_move(m));
  endfunction

  function automatic void homing_tick(input logic pan_sw, input logic tilt_sw);
    if (pan_m.run) begin
      if (pan_m.pd) begin
        pan_m.position = pan_m.position + 16'd1;
        pan_m.pd = 1'b0;
        if (!pan_sw) begin
          pan_m.run = 1'b0;
          if (!tilt_m.run) begin
            start_return();
            return;
          end
        end
      end
      // pan scans forward, coils still stepped on the stopping tick
      pan_m.coils = HALF_STEP_COILS[{pan_m.rhythm, 2'b00} +: 4];
      pan_m = next_rhythm(pan_m);
    end
    if (tilt_m.run) begin
      if (tilt_m.pd) begin
        tilt_m.position = tilt_m.position + 16'd1;
        tilt_m.pd = 1'b0;
        if (!tilt_sw) begin
          tilt_m.run = 1'b0;
          if (!pan_m.run) begin
            start_return();
            return;
          end
        end
      end
      // tilt scans in reverse
      tilt_m.coils = HALF_STEP_COILS[{3'd7 - tilt_m.rhythm, 2'b00} +: 4];
      tilt_m = next_rhythm(tilt_m);
    end
  endfunction

  function automatic out_item_t predict_beat(input in_item_t b);
    out_item_t r;
    logic [1:0] status;
    status = ST_OK;
    case (b.action)
      ACT_TICK: begin
        if (homing_m) begin
          homing_tick(b.pan_origin_switch, b.tilt_end_switch);
        end else begin
          pan_m  = drive_axis(pan_m);
          tilt_m = drive_axis(tilt_m);
        end
      end
      ACT_MOVE: begin
        status = load_move(b);
        if (status != ST_OK) moves_refused++;
      end
      ACT_HOME: begin
        // all flags cleared, then both axes set to scan
        pan_m.rev = 1'b0;  pan_m.red = 1'b0;
        tilt_m.rev = 1'b0; tilt_m.red = 1'b0;
        pan_m.run = 1'b1;  pan_m.pd = 1'b1;  pan_m.ini = 1'b1;
        tilt_m.run = 1'b1; tilt_m.pd = 1'b1; tilt_m.ini = 1'b1;
        pan_m.position  = '0;
        tilt_m.position = '0;
        homing_m = 1'b1;
      end
      default: begin
      end
    endcase
    r.pan_coils   = pan_m.coils;
    r.tilt_coils  = tilt_m.coils;
    r.busy_res    = pan_m.ini | tilt_m.ini;
    r.move_status = status;
    r.pan_active  = pan_m.run;
    r.tilt_active = tilt_m.run;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------------

  // receiver side stall, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_item(input in_item_t beat);
    // valid stays high after a beat; it is only lowered for a gap
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (beat.action)
      ACT_TICK: ticks_sent++;
      ACT_MOVE: moves_sent++;
      ACT_HOME: scans_sent++;
      default: begin
      end
    endcase
    pending_results.push_back(predict_beat(beat));
  endtask

  // drop valid and let every outstanding result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PAN_LIMIT) pan_limit_m = val;
    else tilt_limit_m = val;
  endtask

  task automatic set_limits(input logic [15:0] pan_lim, input logic [15:0] tilt_lim);
    wait_drained();
    write_reg(CFG_PAN_LIMIT, pan_lim);
    write_reg(CFG_TILT_LIMIT, tilt_lim);
  endtask

  // fields a beat does not use still carry random bits
  function automatic in_item_t noise_beat();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  task automatic send_action(input logic [1:0] act);
    in_item_t b;
    b = noise_beat();
    b.action = act;
    send_item(b);
  endtask

  task automatic send_tick(input logic pan_sw, input logic tilt_sw);
    in_item_t b;
    b = noise_beat();
    b.action = ACT_TICK;
    b.pan_origin_switch = pan_sw;
    b.tilt_end_switch   = tilt_sw;
    send_item(b);
  endtask

  function automatic in_item_t move_beat(input logic pen, ten,
                                         input logic [15:0] pamt, tamt,
                                         input logic pdeg, tdeg, prev, trev);
    in_item_t b;
    b = noise_beat();
    b.action          = ACT_MOVE;
    b.pan_enable      = pen;
    b.tilt_enable     = ten;
    b.pan_amount      = pamt;
    b.tilt_amount     = tamt;
    b.pan_in_degrees  = pdeg;
    b.tilt_in_degrees = tdeg;
    b.pan_reverse     = prev;
    b.tilt_reverse    = trev;
    return b;
  endfunction

  // mostly short moves so axes finish, now and then any 16 bit value
  function automatic logic [15:0] rand_amount(input logic deg);
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'd0;
      default: return deg ? 16'($urandom_range(3)) : 16'($urandom_range(4, 1));
    endcase
  endfunction

  function automatic in_item_t random_beat();
    in_item_t b;
    int unsigned pick;
    b = noise_beat();
    pick = $urandom_range(99);
    if (pick < 62) begin
      // switches reached about a third of the time so scans end
      b.action            = ACT_TICK;
      b.pan_origin_switch = $urandom_range(99) >= 35;
      b.tilt_end_switch   = $urandom_range(99) >= 35;
    end else if (pick < 88) begin
      b.action          = ACT_MOVE;
      b.pan_enable      = $urandom_range(9) < 8;
      b.tilt_enable     = $urandom_range(9) < 7;
      b.pan_in_degrees  = $urandom_range(4) == 0;
      b.tilt_in_degrees = $urandom_range(4) == 0;
      b.pan_amount      = rand_amount(b.pan_in_degrees);
      b.tilt_amount     = rand_amount(b.tilt_in_degrees);
    end else if (pick < 96) begin
      b.action = ACT_HOME;
    end else begin
      b.action = ACT_UNUSED;
    end
    return b;
  endfunction

  // ------------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------------

  function automatic string beat_text(input out_item_t b);
    return $sformatf("pan %h tilt %h busy %b status %0d run %b%b", b.pan_coils,
                     b.tilt_coils, b.busy_res, b.move_status, b.pan_active, b.tilt_active);
  endfunction

  always @(posedge clk) begin : check_results
    out_item_t want;
    string     bad;
    if (out_valid === 1'b1 && !out_stall) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with none expected: %s", beat_text(out_beat));
      end else begin
        want = pending_results.pop_front();
        bad  = "";
        if (out_beat.pan_coils !== want.pan_coils) bad = {bad, " pan_coils"};
        if (out_beat.tilt_coils !== want.tilt_coils) bad = {bad, " tilt_coils"};
        if (out_beat.busy_res !== want.busy_res) bad = {bad, " busy_res"};
        if (out_beat.move_status !== want.move_status) bad = {bad, " move_status"};
        if (out_beat.pan_active !== want.pan_active) bad = {bad, " pan_active"};
        if (out_beat.tilt_active !== want.tilt_active) bad = {bad, " tilt_active"};
        if (bad != "") begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d wrong in%s", results_checked, bad);
            $display("  expected %s", beat_text(want));
            $display("  got      %s", beat_text(out_beat));
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("dual_axis_stepper_sequencer_test: done, errors");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // status codes, degree conversion and ratio slowing at reset limits
  task automatic test_move_status();
    send_tick(1'b1, 1'b1);
    // ignored action shows present coils and flags
    send_action(ACT_UNUSED);
    send_item(move_beat(1'b1, 1'b0, 16'd0, 16'd7, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(move_beat(1'b1, 1'b0, 16'd1025, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    // pan accepted, then tilt zero: pan stays loaded
    send_item(move_beat(1'b1, 1'b1, 16'd1, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0));
    // pan zero: tilt part not looked at
    send_item(move_beat(1'b1, 1'b1, 16'd0, 16'd3, 1'b0, 1'b0, 1'b0, 1'b1));
    // 512 degrees wraps to zero periods
    send_item(move_beat(1'b1, 1'b0, 16'd512, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(move_beat(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
    // exactly at the limit, tilt in degrees
    send_item(move_beat(1'b1, 1'b1, 16'd1024, 16'd1, 1'b0, 1'b1, 1'b0, 1'b1));
    repeat (3) send_tick(1'b1, 1'b1);
    // tilt has more periods, pan is slowed
    send_item(move_beat(1'b1, 1'b1, 16'd2, 16'd5, 1'b0, 1'b0, 1'b1, 1'b0));
    repeat (6) send_tick(1'b1, 1'b1);
  endtask

  task automatic test_homing_scan();
    // both switches found on the first tick: pan amount zero, no return move
    send_action(ACT_HOME);
    send_tick(1'b0, 1'b0);
    // one full period on each axis, then both switches reached
    send_action(ACT_HOME);
    repeat (9) send_tick(1'b1, 1'b1);
    repeat (9) send_tick(1'b0, 1'b0);
  endtask

  task automatic test_travel_limits();
    set_limits(16'd0, 16'd0);
    send_item(move_beat(1'b1, 1'b0, 16'd1, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(move_beat(1'b0, 1'b1, 16'd0, 16'd1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(move_beat(1'b0, 1'b1, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    set_limits(16'hFFFF, 16'hFFFF);
    // both counts past the threshold: axes run without end
    send_item(move_beat(1'b1, 1'b1, 16'd2000, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b1));
    repeat (4) send_tick(1'b1, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned idle, stall,
                                     input logic [15:0] pan_lim, tilt_lim,
                                     input int count);
    set_limits(pan_lim, tilt_lim);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) send_item(random_beat());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_move_status();
    test_homing_scan();
    test_travel_limits();
    test_random_traffic(0, 0, LIMIT_RESET, LIMIT_RESET, 110);
    test_random_traffic(48, 0, 16'd20, 16'd20, 110);
    test_random_traffic(0, 48, 16'hFFFF, 16'd3, 110);
    test_random_traffic(19, 19, 16'd7, 16'hFFFF, 110);

    wait_drained();
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;

    $display("checked %0d result beats: %0d ticks, %0d moves (%0d refused), %0d homing scans",
             results_checked, ticks_sent, moves_sent, moves_refused, scans_sent);
    $display("four handshake mixes, travel limits from 0 to 65535, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("dual_axis_stepper_sequencer_test: done, clean");
    end else begin
      $display("dual_axis_stepper_sequencer_test: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/dass_pkg.sv
rtl/dass_div.sv
rtl/dual_axis_stepper_sequencer.sv
rtl/dass_checker.sv
tb/dual_axis_stepper_sequencer_test.sv
